### src/att_pkg.sv
// Package with the word types, command and kind codes and widths of the transfer tracker.
`timescale 1ns / 1ps
`default_nettype none

package att_pkg;

    localparam int SIZE_BITS = 24;
    localparam int ADDR_BITS = 32;
    localparam int SEG_BITS  = SIZE_BITS + 1;

    localparam logic [3:0] CMD_CLEAR        = 4'd0;
    localparam logic [3:0] CMD_START_WRITE  = 4'd1;
    localparam logic [3:0] CMD_FINISH_WRITE = 4'd2;
    localparam logic [3:0] CMD_START_WROUND = 4'd3;
    localparam logic [3:0] CMD_FINISH_WROUND = 4'd4;
    localparam logic [3:0] CMD_START_SYNC   = 4'd5;
    localparam logic [3:0] CMD_FINISH_SYNC  = 4'd6;
    localparam logic [3:0] CMD_START_READ   = 4'd7;
    localparam logic [3:0] CMD_SEGMENT      = 4'd8;
    localparam logic [3:0] CMD_START_RROUND = 4'd9;
    localparam logic [3:0] CMD_FINISH_RROUND = 4'd10;
    localparam logic [3:0] CMD_CANCEL_READ  = 4'd11;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [1:0] KIND_SYNC  = 2'd3;

    localparam int ST_FINISHED = 0;
    localparam int ST_SEG_EX   = 1;
    localparam int ST_TRANS_EX = 2;

    typedef struct packed {
        logic [3:0]           cmd;
        logic [ADDR_BITS-1:0] addr;
        logic [SIZE_BITS-1:0] size;
        logic                 use_dma;
        logic                 autoclose;
        logic                 cont;
        logic                 report_count;
        logic                 discard;
        logic [7:0]           callback_tag;
    } event_t;

    typedef struct packed {
        logic [1:0]           op_kind;
        logic                 busy_res;
        logic                 read_call_open;
        logic                 segment_open;
        logic [SIZE_BITS-1:0] round_bytes;
        logic [2:0]           status;
        logic                 callback_fired;
        logic [7:0]           fired_tag;
        logic [ADDR_BITS-1:0] cur_addr;
        logic [SIZE_BITS-1:0] realized_count;
        logic                 dma_mode;
        logic                 error;
    } result_t;

    typedef struct packed {
        logic [1:0]           kind;
        logic                 dma_flag;
        logic                 autoclose_flag;
        logic                 cont_flag;
        logic [ADDR_BITS-1:0] buf_addr;
        logic [SIZE_BITS-1:0] remaining;
        logic [SEG_BITS-1:0]  segment_fill;
        logic [SIZE_BITS-1:0] round_len;
        logic [7:0]           cb_tag;
        logic [SIZE_BITS-1:0] realized;
        logic                 report_flag;
        logic                 discard_flag;
    } track_state_t;

endpackage

`default_nettype wire

### src/att_in_reg.sv
// Input register stage that holds one event word until the core takes it.
`timescale 1ns / 1ps
`default_nettype none

module att_in_reg
    import att_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   evt_valid,
    output logic        evt_ready,
    input  wire event_t evt,
    output logic        hold_valid,
    input  wire logic   hold_take,
    output event_t      hold_word
);

    logic   valid_reg;
    logic   valid_next;
    event_t word_reg;

    // The stage refills in the same cycle that the core drains it.
    assign evt_ready  = !valid_reg || hold_take;
    assign valid_next = evt_ready ? evt_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_valid && evt_ready)
        begin
            word_reg <= evt;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_word  = word_reg;

endmodule

`default_nettype wire

### src/att_core.sv
// Tracker state registers and the single-pass event update logic.
`timescale 1ns / 1ps
`default_nettype none

module att_core
    import att_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   step,
    input  wire event_t word,
    output result_t     result
);

    track_state_t state_reg;
    track_state_t state_next;

    always_comb
    begin
        track_state_t st;
        logic [2:0]   status;
        logic         fired;
        logic [7:0]   ftag;
        logic         err;
        logic         busy;
        logic         done;
        logic         seg_ex;
        logic         tr_ex;

        st     = state_reg;
        status = 3'b000;
        fired  = 1'b0;
        ftag   = 8'd0;
        err    = 1'b0;
        done   = 1'b0;
        seg_ex = 1'b0;
        tr_ex  = 1'b0;

        unique case (word.cmd)
            CMD_CLEAR:
            begin
                st = '0;
            end
            CMD_START_WRITE:
            begin
                st.kind      = KIND_WRITE;
                st.dma_flag  = word.use_dma;
                st.buf_addr  = word.addr;
                st.remaining = word.size;
                st.cb_tag    = word.callback_tag;
            end
            CMD_FINISH_WRITE:
            begin
                if (state_reg.cb_tag != 8'd0)
                begin
                    fired = 1'b1;
                    ftag  = state_reg.cb_tag;
                end
                st.dma_flag  = 1'b0;
                st.buf_addr  = '0;
                st.remaining = '0;
                st.cb_tag    = 8'd0;
                st.round_len = '0;
            end
            CMD_START_WROUND:
            begin
                st.round_len = word.size;
            end
            CMD_FINISH_WROUND:
            begin
                st.segment_fill = state_reg.segment_fill + SEG_BITS'(state_reg.round_len);
                st.buf_addr     = state_reg.buf_addr + ADDR_BITS'(state_reg.round_len);
                st.remaining    = state_reg.remaining - state_reg.round_len;
                st.round_len    = '0;
            end
            CMD_START_SYNC:
            begin
                if (state_reg.kind == KIND_WRITE)
                begin
                    st.kind   = KIND_SYNC;
                    st.cb_tag = word.callback_tag;
                end
            end
            CMD_FINISH_SYNC:
            begin
                if (state_reg.cb_tag != 8'd0)
                begin
                    fired = 1'b1;
                    ftag  = state_reg.cb_tag;
                end
                st = '0;
            end
            CMD_START_READ:
            begin
                // A read already open, an empty request or a pending round is refused.
                if ((state_reg.kind == KIND_READ && state_reg.remaining != '0)
                    || word.size == '0 || state_reg.round_len != '0)
                begin
                    err = 1'b1;
                end
                else
                begin
                    st.kind           = KIND_READ;
                    st.dma_flag       = word.use_dma;
                    st.autoclose_flag = word.autoclose;
                    st.discard_flag   = word.discard;
                    st.buf_addr       = word.discard ? '0 : word.addr;
                    st.remaining      = word.size;
                    st.report_flag    = word.report_count;
                    st.cb_tag         = word.callback_tag;
                    if (word.report_count)
                    begin
                        st.realized = '0;
                    end
                end
            end
            CMD_SEGMENT:
            begin
                st.kind         = KIND_READ;
                st.segment_fill = SEG_BITS'(word.size);
                st.cont_flag    = word.cont;
            end
            CMD_START_RROUND:
            begin
                if (state_reg.segment_fill[SEG_BITS-1]
                    || SEG_BITS'(state_reg.remaining) < state_reg.segment_fill)
                begin
                    st.round_len = state_reg.remaining;
                end
                else
                begin
                    st.round_len = state_reg.segment_fill[SIZE_BITS-1:0];
                end
            end
            CMD_FINISH_RROUND:
            begin
                if (state_reg.report_flag)
                begin
                    st.realized = state_reg.realized + state_reg.round_len;
                end
                st.segment_fill = state_reg.segment_fill - SEG_BITS'(state_reg.round_len);
                if (!state_reg.discard_flag)
                begin
                    st.buf_addr = state_reg.buf_addr + ADDR_BITS'(state_reg.round_len);
                end
                st.remaining = state_reg.remaining - state_reg.round_len;
                st.round_len = '0;
                done   = (st.remaining == '0);
                seg_ex = (st.segment_fill == '0)
                         && (state_reg.autoclose_flag || st.remaining != '0);
                tr_ex  = seg_ex && !state_reg.cont_flag;
                if (done || tr_ex)
                begin
                    st.dma_flag       = 1'b0;
                    st.autoclose_flag = 1'b0;
                    st.buf_addr       = '0;
                    st.discard_flag   = 1'b1;
                    st.remaining      = '0;
                    st.cb_tag         = 8'd0;
                    st.report_flag    = 1'b0;
                    status[ST_FINISHED] = 1'b1;
                end
                if (seg_ex)
                begin
                    st.segment_fill   = '1;
                    status[ST_SEG_EX] = 1'b1;
                    if (status[ST_FINISHED])
                    begin
                        st.kind         = KIND_NONE;
                        st.segment_fill = '0;
                    end
                end
                status[ST_TRANS_EX] = tr_ex;
            end
            CMD_CANCEL_READ:
            begin
                st.dma_flag       = 1'b0;
                st.autoclose_flag = 1'b0;
                st.buf_addr       = '0;
                st.discard_flag   = 1'b1;
                st.remaining      = '0;
                st.cb_tag         = 8'd0;
                st.report_flag    = 1'b0;
                if (!(state_reg.kind == KIND_READ && !state_reg.segment_fill[SEG_BITS-1]))
                begin
                    st.kind         = KIND_NONE;
                    st.segment_fill = '0;
                end
            end
            default:
            begin
                st = state_reg;
            end
        endcase

        if (st.kind == KIND_READ)
        begin
            busy = (st.remaining != '0);
        end
        else if (st.kind == KIND_WRITE)
        begin
            busy = (st.buf_addr != '0);
        end
        else
        begin
            busy = (st.kind == KIND_SYNC);
        end

        state_next = st;

        result.op_kind        = st.kind;
        result.busy_res       = busy;
        result.read_call_open = (st.kind == KIND_READ) && (st.remaining != '0);
        result.segment_open   = (st.kind == KIND_READ) && !st.segment_fill[SEG_BITS-1];
        result.round_bytes    = st.round_len;
        result.status         = status;
        result.callback_fired = fired;
        result.fired_tag      = ftag;
        result.cur_addr       = st.buf_addr;
        result.realized_count = st.realized;
        result.dma_mode       = st.dma_flag;
        result.error          = err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (step)
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### src/att_out_reg.sv
// Result register that holds one result word until the receiver takes it.
`timescale 1ns / 1ps
`default_nettype none

module att_out_reg
    import att_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load_valid,
    output logic         load_ready,
    input  wire result_t load_word,
    output logic         res_valid,
    input  wire logic    res_ready,
    output result_t      res
);

    logic    valid_reg;
    logic    valid_next;
    result_t word_reg;

    assign load_ready = !valid_reg || res_ready;
    assign valid_next = load_ready ? load_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_valid && load_ready)
        begin
            word_reg <= load_word;
        end
    end

    assign res_valid = valid_reg;
    assign res       = word_reg;

endmodule

`default_nettype wire

### src/async_transfer_tracker_top.sv
// Top level of the asynchronous transfer tracker: input register, core and result register.
`timescale 1ns / 1ps
`default_nettype none

// The tracker keeps the bookkeeping of one asynchronous endpoint transfer.
// Event words arrive on the evt channel (evt_valid, evt_ready, evt) and each
// one produces exactly one result word on the res channel (res_valid,
// res_ready, res), in the same order. A word is taken at a rising edge where
// valid and ready are both high.
// An accepted event is captured in the input register, the core updates
// its state from it in one pass, and the result is captured in the result
// register, from which it is presented on the res channel.
// Throughput is one event per cycle while the receiver does not stall, set by
// the one-pass core update, which reads the state that the previous event left.
// When the receiver stalls, the result register holds its word, the input
// register holds the next event and evt_ready drops only once both are full;
// no word is lost or repeated.
// Reset (rst_n low, asynchronous) empties both registers and clears every
// field of the tracker state to zero, that is kind none and no segment.
// A clear event (command zero) does the same to the state at run time.
module async_transfer_tracker_top
    import att_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   evt_valid,
    output logic        evt_ready,
    input  wire event_t evt,
    output logic        res_valid,
    input  wire logic   res_ready,
    output result_t     res
);

    logic    hold_valid;
    logic    load_ready;
    logic    step;
    event_t  hold_word;
    result_t core_result;

    // The core advances only when its result has a place to go.
    assign step = hold_valid && load_ready;

    att_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .evt_valid  (evt_valid),
        .evt_ready  (evt_ready),
        .evt        (evt),
        .hold_valid (hold_valid),
        .hold_take  (step),
        .hold_word  (hold_word)
    );

    att_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .word   (hold_word),
        .result (core_result)
    );

    att_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (hold_valid),
        .load_ready (load_ready),
        .load_word  (core_result),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

endmodule

`default_nettype wire

### src/att_checker.sv
// Port-level checks on the tracker's result words, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module att_checker
    import att_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    evt_valid,
    input wire logic    evt_ready,
    input wire logic    res_valid,
    input wire logic    res_ready,
    input wire result_t res
);

    // A stalled result word stays in place.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result word changed while stalled");

    // A fired callback always carries a real tag.
    a_tag_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.callback_fired |-> res.fired_tag != 8'd0)
        else $error("callback fired with tag zero");

    // A rejected start read has no round status and fires no callback.
    a_error_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.error |-> res.status == 3'b000 && !res.callback_fired)
        else $error("rejected read reported status or callback");

    // An open read call means a busy read.
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.read_call_open |-> res.busy_res && res.op_kind == KIND_READ)
        else $error("read call open without busy read kind");

    // An accepted event is answered through the input and result registers when nothing stalls.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_ready && res_ready ##1 res_ready |=> res_valid)
        else $error("result word missing after accepted event");

endmodule

bind async_transfer_tracker_top att_checker u_att_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .evt_valid (evt_valid),
    .evt_ready (evt_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);

`default_nettype wire
